FILE: hw/rtl/rrqs_pkg.sv
// ----------------------------------------------------------------------------
// rrqs_pkg
// Shared types and codes for the round-robin quantum scheduler.
// ----------------------------------------------------------------------------
package rrqs_pkg;

  localparam int unsigned MAX_TASKS_DEF = 16;
  localparam logic [7:0]  QUANTUM_RST   = 8'd5;

  // command opcodes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_CREATE = 3'd1;
  localparam logic [2:0] OP_YIELD  = 3'd2;
  localparam logic [2:0] OP_TERM   = 3'd3;
  localparam logic [2:0] OP_GETPID = 3'd4;

  // result status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_NO_TASK = 2'd2;

  // task states
  localparam logic [2:0] TS_EMPTY    = 3'd0;
  localparam logic [2:0] TS_NEW      = 3'd1;
  localparam logic [2:0] TS_RUNNABLE = 3'd2;
  localparam logic [2:0] TS_RUNNING  = 3'd3;
  localparam logic [2:0] TS_ZOMBIE   = 3'd4;

  typedef logic [3:0] slot_out_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        system_task;
    logic [31:0] exit_value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        switched;
    logic        first_run;
    slot_out_t   running_slot;
    logic        running_system;
    logic [31:0] pid_value;
  } out_t;

  // one task table entry
  typedef struct packed {
    logic [2:0]  tstate;
    logic [7:0]  qleft;
    logic [7:0]  qreload;
    logic [31:0] pid;
    logic        mode;
    logic [31:0] exit_val;
  } entry_t;

  function automatic logic sched_ok(input logic [2:0] st);
    sched_ok = (st == TS_NEW) || (st == TS_RUNNABLE) || (st == TS_RUNNING);
  endfunction

endpackage

FILE: hw/rtl/rrqs_ram.sv
// ----------------------------------------------------------------------------
// rrqs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rrqs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/round_robin_quantum_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler
// Task table scheduler with a per-task time quantum and round-robin rotation.
// ----------------------------------------------------------------------------
// One command transaction in, one result transaction out. The task table sits
// in a single RAM with a registered read port; slots are handed out in order
// and never freed, so the newest slot doubles as the fill count and no clear
// pass is needed after reset. Create, get-pid, unused opcodes and commands
// with no current task go from accept straight to the result. Tick, yield and
// terminate read the current entry; when the current task keeps running they
// write it back and finish, else they walk the table one slot per cycle
// toward older tasks. A switch costs a second write-back after the walk up
// to the target. A finished result waits in the output register while the
// next command is already taken. The default quantum is written through
// cfg_we/cfg_wdata.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler #(
  parameter int unsigned MAX_TASKS = rrqs_pkg::MAX_TASKS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  // command channel
  input  logic            in_valid,
  output logic            in_stall,
  input  rrqs_pkg::in_t   in_data,
  // result channel
  output logic            out_valid,
  input  logic            out_stall,
  output rrqs_pkg::out_t  out_data,
  // configuration
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata
);

  localparam int unsigned SLOT_W = $clog2(MAX_TASKS);
  localparam int unsigned ENT_W  = $bits(rrqs_pkg::entry_t);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TASKS - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CUR    = 5'b00010,  // current entry on RAM output
    S_SCAN   = 5'b00100,  // walking older slots
    S_SWITCH = 5'b01000,  // write back the task switched to
    S_OUT    = 5'b10000   // hand result to output register
  } state_t;

  // previous slot in rotation order, wrapping from slot 0 to the newest
  function automatic logic [SLOT_W-1:0] older(input logic [SLOT_W-1:0] s,
                                              input logic [SLOT_W-1:0] newest);
    older = (s == '0) ? newest : s - 1'b1;
  endfunction

  // control state
  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              cur_valid_r, cur_valid_nxt;
  logic [SLOT_W-1:0] cur_slot_r, cur_slot_nxt;
  logic [SLOT_W-1:0] newest_r, newest_nxt;
  logic [31:0]       last_pid_r, last_pid_nxt;
  logic [7:0]        def_q_r, def_q_nxt;

  // payload / working registers
  rrqs_pkg::out_t    out_data_r, out_data_nxt;
  logic [31:0]       cur_pid_r, cur_pid_nxt;     // cached pid of current task
  logic              cur_mode_r, cur_mode_nxt;   // cached mode of current task
  logic [2:0]        op_r, op_nxt;
  logic [31:0]       exit_r, exit_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              switched_r, switched_nxt;
  logic              first_r, first_nxt;
  logic              create_ok_r, create_ok_nxt;
  rrqs_pkg::entry_t  cur_e_r, cur_e_nxt;         // modified current entry
  rrqs_pkg::entry_t  nxt_e_r, nxt_e_nxt;         // entry being switched to
  logic [SLOT_W-1:0] nxt_slot_r, nxt_slot_nxt;
  logic [SLOT_W-1:0] scan_r, scan_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;

  // RAM port
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  rrqs_pkg::entry_t  ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;
  rrqs_pkg::entry_t  rd_e;

  rrqs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_e = rrqs_pkg::entry_t'(ram_rdata);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // read address runs one slot ahead of the entry being checked
  always_comb begin
    unique case (state_r)
      S_CUR:   ram_raddr = older(cur_slot_r, newest_r);
      S_SCAN:  ram_raddr = older(scan_r, newest_r);
      default: ram_raddr = cur_slot_r;
    endcase
  end

  always_comb begin
    rrqs_pkg::entry_t se;
    rrqs_pkg::entry_t ce;
    logic [SLOT_W-1:0] s_new;
    logic [7:0]        q_dec;
    logic              ok;

    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cur_valid_nxt = cur_valid_r;
    cur_slot_nxt  = cur_slot_r;
    newest_nxt    = newest_r;
    last_pid_nxt  = last_pid_r;
    def_q_nxt     = def_q_r;
    out_data_nxt  = out_data_r;
    cur_pid_nxt   = cur_pid_r;
    cur_mode_nxt  = cur_mode_r;
    op_nxt        = op_r;
    exit_nxt      = exit_r;
    status_nxt    = status_r;
    switched_nxt  = switched_r;
    first_nxt     = first_r;
    create_ok_nxt = create_ok_r;
    cur_e_nxt     = cur_e_r;
    nxt_e_nxt     = nxt_e_r;
    nxt_slot_nxt  = nxt_slot_r;
    scan_nxt      = scan_r;
    cnt_nxt       = cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_slot_r;
    ram_wdata     = cur_e_r;

    se    = (scan_r == cur_slot_r) ? cur_e_r : rd_e;  // current not yet written
    ok    = rrqs_pkg::sched_ok(se.tstate);
    ce    = rd_e;
    q_dec = rd_e.qleft - 8'(rd_e.qleft != 8'd0);
    s_new = cur_valid_r ? newest_r + 1'b1 : '0;

    if (cfg_we) begin
      def_q_nxt = cfg_wdata;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_data.opcode;
          exit_nxt      = in_data.exit_value;
          status_nxt    = rrqs_pkg::STS_OK;
          switched_nxt  = 1'b0;
          first_nxt     = 1'b0;
          create_ok_nxt = 1'b0;
          state_nxt     = S_OUT;
          priority if (in_data.opcode == rrqs_pkg::OP_CREATE) begin
            if (cur_valid_r && newest_r == LAST_SLOT) begin
              status_nxt = rrqs_pkg::STS_FULL;
            end else begin
              ram_we              = 1'b1;
              ram_waddr           = s_new;
              ram_wdata.tstate    = rrqs_pkg::TS_NEW;
              ram_wdata.qleft     = def_q_r;
              ram_wdata.qreload   = def_q_r;
              ram_wdata.pid       = last_pid_r + 32'd1;
              ram_wdata.mode      = in_data.system_task;
              ram_wdata.exit_val  = '0;
              newest_nxt          = s_new;
              last_pid_nxt        = last_pid_r + 32'd1;
              create_ok_nxt       = 1'b1;
              if (!cur_valid_r) begin
                cur_valid_nxt = 1'b1;
                cur_slot_nxt  = s_new;
                cur_pid_nxt   = last_pid_r + 32'd1;
                cur_mode_nxt  = in_data.system_task;
              end
            end
          end else if (in_data.opcode == rrqs_pkg::OP_TICK ||
                       in_data.opcode == rrqs_pkg::OP_YIELD ||
                       in_data.opcode == rrqs_pkg::OP_TERM ||
                       in_data.opcode == rrqs_pkg::OP_GETPID) begin
            if (!cur_valid_r) begin
              status_nxt = rrqs_pkg::STS_NO_TASK;
            end else if (in_data.opcode != rrqs_pkg::OP_GETPID) begin
              state_nxt = S_CUR;
            end
          end else begin
            // unused opcodes: nothing changes, status ok
          end
        end
      end

      S_CUR: begin
        if (op_r == rrqs_pkg::OP_TERM) begin
          ce.tstate    = rrqs_pkg::TS_ZOMBIE;
          ce.qleft     = 8'd1;
          ce.exit_val  = exit_r;
        end else if (rd_e.tstate == rrqs_pkg::TS_RUNNING) begin
          ce.qleft = q_dec;
        end
        cur_e_nxt = ce;
        scan_nxt  = older(cur_slot_r, newest_r);
        cnt_nxt   = '0;
        if (op_r != rrqs_pkg::OP_TERM && rd_e.tstate == rrqs_pkg::TS_RUNNING &&
            q_dec != 8'd0) begin
          // quantum not used up: keep running
          ram_we    = 1'b1;
          ram_wdata = ce;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (ok && scan_r != cur_slot_r) begin
          // switch away: demote current, remember the target
          ram_we            = 1'b1;
          ram_wdata         = cur_e_r;
          ram_wdata.qleft   = 8'd0;
          if (cur_e_r.tstate == rrqs_pkg::TS_RUNNING) begin
            ram_wdata.tstate = rrqs_pkg::TS_RUNNABLE;
          end
          nxt_e_nxt    = se;
          nxt_slot_nxt = scan_r;
          state_nxt    = S_SWITCH;
        end else if (ok || cnt_r == newest_r) begin
          // current task stays, even a zombie when nothing else can run
          ram_we          = 1'b1;
          ram_wdata       = cur_e_r;
          ram_wdata.qleft = cur_e_r.qreload;
          state_nxt       = S_OUT;
        end else begin
          cnt_nxt  = cnt_r + 1'b1;
          scan_nxt = older(scan_r, newest_r);
        end
      end

      S_SWITCH: begin
        ram_we           = 1'b1;
        ram_waddr        = nxt_slot_r;
        ram_wdata        = nxt_e_r;
        ram_wdata.tstate = rrqs_pkg::TS_RUNNING;
        ram_wdata.qleft  = nxt_e_r.qreload;
        first_nxt        = (nxt_e_r.tstate == rrqs_pkg::TS_NEW);
        switched_nxt     = 1'b1;
        cur_slot_nxt     = nxt_slot_r;
        cur_pid_nxt      = nxt_e_r.pid;
        cur_mode_nxt     = nxt_e_r.mode;
        state_nxt        = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.status         = status_r;
          out_data_nxt.switched       = switched_r;
          out_data_nxt.first_run      = first_r;
          out_data_nxt.running_slot   = cur_valid_r ?
                                        rrqs_pkg::slot_out_t'(cur_slot_r) : '0;
          out_data_nxt.running_system = cur_valid_r ? cur_mode_r : 1'b0;
          out_data_nxt.pid_value      = create_ok_r ? last_pid_r :
                                        (cur_valid_r ? cur_pid_r : 32'd0);
          state_nxt                   = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cur_valid_r <= 1'b0;
      cur_slot_r  <= '0;
      newest_r    <= '0;
      last_pid_r  <= '0;
      def_q_r     <= rrqs_pkg::QUANTUM_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_slot_r  <= cur_slot_nxt;
      newest_r    <= newest_nxt;
      last_pid_r  <= last_pid_nxt;
      def_q_r     <= def_q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    cur_pid_r   <= cur_pid_nxt;
    cur_mode_r  <= cur_mode_nxt;
    op_r        <= op_nxt;
    exit_r      <= exit_nxt;
    status_r    <= status_nxt;
    switched_r  <= switched_nxt;
    first_r     <= first_nxt;
    create_ok_r <= create_ok_nxt;
    cur_e_r     <= cur_e_nxt;
    nxt_e_r     <= nxt_e_nxt;
    nxt_slot_r  <= nxt_slot_nxt;
    scan_r      <= scan_nxt;
    cnt_r       <= cnt_nxt;
  end

  // current task always lies inside the filled part of the table
  a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> cur_slot_r <= newest_r)
    else $error("current slot beyond newest slot");

  // without a current task nothing was ever created
  a_empty_table: assert property (@(posedge clk) disable iff (!rst_n)
    !cur_valid_r |-> (newest_r == '0 && last_pid_r == 32'd0))
    else $error("table state without a current task");

  // a switch always targets another slot
  a_switch_other: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWITCH) |-> nxt_slot_r != cur_slot_r)
    else $error("switch to the current slot");

  // write-backs during the walk only touch the current entry
  a_wb_current: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (state_r == S_CUR || state_r == S_SCAN)) |-> ram_waddr == cur_slot_r)
    else $error("walk wrote a slot other than current");

  // walk never runs past the filled part of the table
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> cnt_r <= newest_r)
    else $error("walk counter past newest slot");

endmodule

FILE: test/tb_round_robin_quantum_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_round_robin_quantum_scheduler
// Self-checking bench for the round-robin quantum scheduler.
// ----------------------------------------------------------------------------
// A task-table model in the bench predicts every result transaction from the
// accepted command transactions. A short directed sequence covers commands
// with no task, the first task that is never run, zero and maximum quanta,
// and terminate. Random phases follow. Each phase starts with a quantum
// setting written while the block is idle. The last phase retires every task
// and fills the table. Both sides idle at random, and one stretch holds the
// result channel off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module tb_round_robin_quantum_scheduler;

  localparam int unsigned MAX_SLOTS = rrqs_pkg::MAX_TASKS_DEF;

  // opcodes the block leaves unused
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  rrqs_pkg::in_t   in_data;
  logic            out_valid;
  logic            out_stall;
  rrqs_pkg::out_t  out_data;
  logic            cfg_we;
  logic [7:0]      cfg_wdata;

  round_robin_quantum_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Task-table model: one entry per slot plus the scheduler registers.
  // --------------------------------------------------------------------------
  logic [2:0]  tt_state   [MAX_SLOTS] = '{default: rrqs_pkg::TS_EMPTY};
  logic [7:0]  tt_qleft   [MAX_SLOTS] = '{default: '0};
  logic [7:0]  tt_qreload [MAX_SLOTS] = '{default: '0};
  logic [31:0] tt_pid     [MAX_SLOTS] = '{default: '0};
  logic [31:0] tt_exit    [MAX_SLOTS] = '{default: '0};
  logic        tt_mode    [MAX_SLOTS] = '{default: 1'b0};
  int unsigned run_slot    = 0;
  bit          run_valid   = 1'b0;
  int unsigned top_slot    = 0;
  logic [31:0] pid_counter = '0;
  logic [7:0]  quantum_cfg = rrqs_pkg::QUANTUM_RST;

  rrqs_pkg::out_t sched_results[$];   // results owed by the block, oldest first
  int unsigned mismatches = 0;

  // stimulus knobs
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  int unsigned rx_hold = 0;  // one-shot long hold-off for the receiver

  function automatic bit schedulable(logic [2:0] st);
    return st inside {rrqs_pkg::TS_NEW, rrqs_pkg::TS_RUNNABLE, rrqs_pkg::TS_RUNNING};
  endfunction

  // walk toward older tasks, wrap from slot 0 to the newest
  function automatic int unsigned prev_slot(int unsigned s);
    return (s == 0) ? top_slot : s - 1;
  endfunction

  // Applies one command to the model and returns the result it owes.
  function automatic rrqs_pkg::out_t sched_decide(rrqs_pkg::in_t cmd);
    rrqs_pkg::out_t r;
    int unsigned    nxt;
    int unsigned    n;
    bit             found;
    bit             expired;
    bit             new_pid;
    r = '0;
    new_pid = 1'b0;
    unique case (cmd.opcode)
      rrqs_pkg::OP_CREATE: begin
        if (run_valid && top_slot >= MAX_SLOTS - 1) begin
          r.status = rrqs_pkg::STS_FULL;
        end else begin
          nxt = run_valid ? top_slot + 1 : 0;
          top_slot = nxt;
          if (!run_valid) begin
            run_valid = 1'b1;
            run_slot  = nxt;
          end
          pid_counter      = pid_counter + 1;
          tt_pid[nxt]      = pid_counter;
          tt_mode[nxt]     = cmd.system_task;
          tt_qreload[nxt]  = quantum_cfg;
          tt_qleft[nxt]    = quantum_cfg;
          tt_state[nxt]    = rrqs_pkg::TS_NEW;
          r.pid_value      = pid_counter;
          new_pid          = 1'b1;
        end
      end
      rrqs_pkg::OP_TICK, rrqs_pkg::OP_YIELD, rrqs_pkg::OP_TERM: begin
        if (!run_valid) begin
          r.status = rrqs_pkg::STS_NO_TASK;
        end else begin
          if (cmd.opcode == rrqs_pkg::OP_TERM) begin
            tt_qleft[run_slot] = 8'd1;
            tt_state[run_slot] = rrqs_pkg::TS_ZOMBIE;
            tt_exit[run_slot]  = cmd.exit_value;
          end
          // only a running task burns quantum; anything else reschedules
          expired = 1'b1;
          if (tt_state[run_slot] == rrqs_pkg::TS_RUNNING) begin
            if (tt_qleft[run_slot] != 0) tt_qleft[run_slot]--;
            expired = (tt_qleft[run_slot] == 0);
          end
          if (expired) begin
            nxt = prev_slot(run_slot);
            found = 1'b0;
            for (n = 0; n <= top_slot && !found; n++) begin
              if (schedulable(tt_state[nxt])) found = 1'b1;
              else nxt = prev_slot(nxt);
            end
            if (!found) nxt = run_slot;
            if (nxt == run_slot) begin
              tt_qleft[run_slot] = tt_qreload[run_slot];
            end else begin
              if (tt_state[run_slot] == rrqs_pkg::TS_RUNNING)
                tt_state[run_slot] = rrqs_pkg::TS_RUNNABLE;
              tt_qleft[run_slot] = '0;
              r.first_run = (tt_state[nxt] == rrqs_pkg::TS_NEW);
              r.switched  = 1'b1;
              run_slot = nxt;
              tt_qleft[nxt] = tt_qreload[nxt];
              tt_state[nxt] = rrqs_pkg::TS_RUNNING;
            end
          end
        end
      end
      rrqs_pkg::OP_GETPID: begin
        if (!run_valid) r.status = rrqs_pkg::STS_NO_TASK;
      end
      default: ;
    endcase
    if (run_valid) begin
      r.running_slot   = rrqs_pkg::slot_out_t'(run_slot);
      r.running_system = tt_mode[run_slot];
      if (!new_pid) r.pid_value = tt_pid[run_slot];
    end
    return r;
  endfunction

  function automatic int unsigned live_tasks();
    int unsigned cnt;
    cnt = 0;
    for (int unsigned s = 0; s < MAX_SLOTS; s++)
      if (schedulable(tt_state[s])) cnt++;
    return cnt;
  endfunction

  function automatic rrqs_pkg::in_t command_of(logic [2:0] op, logic sys,
                                               logic [31:0] code);
    rrqs_pkg::in_t c;
    c.opcode      = op;
    c.system_task = sys;
    c.exit_value  = code;
    return c;
  endfunction

  // Random command. Terminate turns into yield while keep_alive or fewer
  // tasks are live, so the table keeps something to rotate through.
  function automatic rrqs_pkg::in_t make_command(int unsigned create_pct,
                                                 int unsigned term_pct,
                                                 int unsigned keep_alive);
    int unsigned roll;
    logic [2:0]  op;
    roll = $urandom_range(0, 99);
    if (roll < create_pct) op = rrqs_pkg::OP_CREATE;
    else if (roll < create_pct + term_pct)
      op = (live_tasks() > keep_alive) ? rrqs_pkg::OP_TERM : rrqs_pkg::OP_YIELD;
    else if (roll < 60) op = rrqs_pkg::OP_TICK;
    else if (roll < 80) op = rrqs_pkg::OP_YIELD;
    else if (roll < 93) op = rrqs_pkg::OP_GETPID;
    else op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    return command_of(op, 1'($urandom), $urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Command side: optional gap, then hold the transaction until accepted.
  // in_valid stays high on return so back-to-back transactions have no bubble.
  // --------------------------------------------------------------------------
  task automatic send_command(input rrqs_pkg::in_t cmd);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (in_stall);
    sched_results.push_back(sched_decide(cmd));
  endtask

  // sender pause: nothing offered until every owed result is back
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (sched_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_quantum(input logic [7:0] q);
    wait_all_results();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= q;
    @(posedge clk);
    cfg_we    <= 1'b0;
    quantum_cfg = q;
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall for a drawn number of cycles per transaction, or for
  // the long hold-off when one is requested.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (rx_hold != 0) begin
        hold = rx_hold;
        rx_hold = 0;
      end else begin
        hold = rx_idle ? $urandom_range(0, 10) : 0;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    rrqs_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sched_results.size() == 0) begin
        $display("%0t: result with none owed, expected none actual %p", $time, out_data);
        mismatches++;
      end else begin
        want = sched_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("switched", 32'(want.switched), 32'(out_data.switched));
        check_field("first_run", 32'(want.first_run), 32'(out_data.first_run));
        check_field("running_slot", 32'(want.running_slot),
                    32'(out_data.running_slot));
        check_field("running_system", 32'(want.running_system),
                    32'(out_data.running_system));
        check_field("pid_value", want.pid_value, out_data.pid_value);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // every command but create with an empty table, unused opcodes included
  task automatic test_no_task();
    send_command(command_of(rrqs_pkg::OP_TICK, 1'b0, '0));
    send_command(command_of(rrqs_pkg::OP_YIELD, 1'b1, '1));
    send_command(command_of(rrqs_pkg::OP_TERM, 1'b0, 32'hFFFF_FFFF));
    send_command(command_of(rrqs_pkg::OP_GETPID, 1'b1, '0));
    send_command(command_of(OP_SPARE_LO, 1'b0, '1));
    send_command(command_of(OP_SPARE_MID, 1'b1, '0));
    send_command(command_of(OP_SPARE_HI, 1'b0, '0));
  endtask

  // first task becomes current but stays New until something switches to it
  task automatic test_first_task();
    set_quantum(8'd0);
    send_command(command_of(rrqs_pkg::OP_CREATE, 1'b1, '0));
    send_command(command_of(rrqs_pkg::OP_TICK, 1'b0, '0));
    send_command(command_of(rrqs_pkg::OP_GETPID, 1'b0, '0));
  endtask

  // max quantum task switched to and killed; zero quantum reloads every tick
  task automatic test_quantum_extremes();
    set_quantum(8'd255);
    send_command(command_of(rrqs_pkg::OP_CREATE, 1'b0, '0));
    send_command(command_of(rrqs_pkg::OP_TICK, 1'b0, '0));
    send_command(command_of(rrqs_pkg::OP_TICK, 1'b1, '1));
    send_command(command_of(rrqs_pkg::OP_YIELD, 1'b0, '0));
    send_command(command_of(rrqs_pkg::OP_TERM, 1'b0, 32'hFFFF_FFFF));
    send_command(command_of(rrqs_pkg::OP_TICK, 1'b0, '0));
    send_command(command_of(rrqs_pkg::OP_TICK, 1'b0, '0));
    set_quantum(8'd1);
    send_command(command_of(rrqs_pkg::OP_CREATE, 1'b1, '0));
    send_command(command_of(rrqs_pkg::OP_TICK, 1'b0, '0));
    send_command(command_of(rrqs_pkg::OP_TICK, 1'b0, '0));
    send_command(command_of(rrqs_pkg::OP_TERM, 1'b1, 32'h0000_0000));
    send_command(command_of(OP_SPARE_HI, 1'b1, '1));
  endtask

  // long receiver hold-off, sender offering back to back
  task automatic test_output_backpressure();
    set_quantum(8'd3);
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    rx_hold = 200;
    repeat (30) send_command(make_command(6, 3, 3));
    wait_all_results();
    tx_idle = 1'b1;
  endtask

  // random phases, each with its own quantum and idling mix
  task automatic test_rotation_phases();
    logic [7:0] quanta [8] = '{8'd2, 8'd1, 8'd0, 8'd4, 8'd3, 8'd9, 8'd6, 8'd5};
    quanta[7] = 8'($urandom_range(1, 12));
    for (int p = 0; p < 8; p++) begin
      set_quantum(quanta[p]);
      tx_idle = (p % 3) != 1;
      rx_idle = (p % 3) != 2;
      repeat (130) send_command(make_command((p < 4) ? 4 : 2, 3, 3));
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // table full on create, then every task retired: nothing left to schedule
  task automatic test_all_retired();
    set_quantum(8'd1);
    repeat (160) send_command(make_command(10, 30, 0));
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_no_task();
    test_first_task();
    test_quantum_extremes();
    test_output_backpressure();
    test_rotation_phases();
    test_all_retired();

    wait_all_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
